>>> rtl/ppq_pkg.sv
`default_nettype none
package ppq_pkg;

  localparam int STATE_DIM = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int REG_W     = 31;
  localparam int WIDE_W    = 64;
  // squared distance of an active item stays below threshold_squared << FRAC_BITS
  localparam int D2_W      = REG_W + FRAC_BITS;
  localparam int ROOT_W    = (D2_W + 1) / 2;
  localparam int DIV_W     = VAL_W + FRAC_BITS + 1;
  localparam int NRES      = 21;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_X1     = 3'd0,
    CFG_Y1     = 3'd1,
    CFG_X2     = 3'd2,
    CFG_Y2     = 3'd3,
    CFG_THR    = 3'd4,
    CFG_THR_SQ = 3'd5,
    CFG_WEIGHT = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PEN  = 2'd0,
    KIND_GRAD = 2'd1,
    KIND_HESS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEL_X1 = 2'd0,
    SEL_Y1 = 2'd1,
    SEL_X2 = 2'd2,
    SEL_Y2 = 2'd3
  } sel_t;

  typedef enum logic [2:0] {
    SRC_PEN = 3'd0,
    SRC_GX  = 3'd1,
    SRC_GY  = 3'd2,
    SRC_HXX = 3'd3,
    SRC_HYY = 3'd4,
    SRC_HXY = 3'd5
  } src_t;

  typedef struct packed {
    kind_t kind;
    sel_t  row;
    sel_t  col;
    src_t  src;
    logic  neg;
  } emit_t;

  typedef struct packed {
    logic [IDX_W-1:0] x1;
    logic [IDX_W-1:0] y1;
    logic [IDX_W-1:0] x2;
    logic [IDX_W-1:0] y2;
    logic [REG_W-1:0] thr;
    logic [REG_W-1:0] thr_sq;
    logic [REG_W-1:0] weight;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] dx;
    logic signed [VAL_W-1:0] dy;
    logic [D2_W-1:0]         d2;
    logic                    active;
  } job_t;

  function automatic emit_t emit_entry(input logic [4:0] i);
    emit_t e;
    unique case (i)
      5'd1:    e = '{KIND_GRAD, SEL_X1, SEL_X1, SRC_GX, 1'b0};
      5'd2:    e = '{KIND_GRAD, SEL_X2, SEL_X1, SRC_GX, 1'b1};
      5'd3:    e = '{KIND_GRAD, SEL_Y1, SEL_X1, SRC_GY, 1'b0};
      5'd4:    e = '{KIND_GRAD, SEL_Y2, SEL_X1, SRC_GY, 1'b1};
      5'd5:    e = '{KIND_HESS, SEL_X1, SEL_X1, SRC_HXX, 1'b0};
      5'd6:    e = '{KIND_HESS, SEL_X1, SEL_X2, SRC_HXX, 1'b1};
      5'd7:    e = '{KIND_HESS, SEL_X2, SEL_X1, SRC_HXX, 1'b1};
      5'd8:    e = '{KIND_HESS, SEL_X2, SEL_X2, SRC_HXX, 1'b0};
      5'd9:    e = '{KIND_HESS, SEL_Y1, SEL_Y1, SRC_HYY, 1'b0};
      5'd10:   e = '{KIND_HESS, SEL_Y1, SEL_Y2, SRC_HYY, 1'b1};
      5'd11:   e = '{KIND_HESS, SEL_Y2, SEL_Y1, SRC_HYY, 1'b1};
      5'd12:   e = '{KIND_HESS, SEL_Y2, SEL_Y2, SRC_HYY, 1'b0};
      5'd13:   e = '{KIND_HESS, SEL_X1, SEL_Y1, SRC_HXY, 1'b0};
      5'd14:   e = '{KIND_HESS, SEL_Y1, SEL_X1, SRC_HXY, 1'b0};
      5'd15:   e = '{KIND_HESS, SEL_X1, SEL_Y2, SRC_HXY, 1'b1};
      5'd16:   e = '{KIND_HESS, SEL_Y2, SEL_X1, SRC_HXY, 1'b1};
      5'd17:   e = '{KIND_HESS, SEL_X2, SEL_Y1, SRC_HXY, 1'b1};
      5'd18:   e = '{KIND_HESS, SEL_Y1, SEL_X2, SRC_HXY, 1'b1};
      5'd19:   e = '{KIND_HESS, SEL_X2, SEL_Y2, SRC_HXY, 1'b0};
      5'd20:   e = '{KIND_HESS, SEL_Y2, SEL_X2, SRC_HXY, 1'b0};
      default: e = '{KIND_PEN, SEL_X1, SEL_X1, SRC_PEN, 1'b0};
    endcase
    return e;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (32'(i) >= STATE_DIM) r = IDX_W'(STATE_DIM - 1);
    else r = i;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ppq_fifo.sv
`default_nettype none
module ppq_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppq_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output ppq_pkg::job_t rdata,
  output logic          empty
);
  import ppq_pkg::*;

  job_t        mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

>>> rtl/ppq_front.sv
`default_nettype none
module ppq_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_first_x,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_first_y,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_second_x,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_second_y,
  input  logic [ppq_pkg::REG_W-1:0]        thr_sq,
  output logic                             job_push,
  input  logic                             job_full,
  output ppq_pkg::job_t                    job
);
  import ppq_pkg::*;

  logic                     v1_r, v2_r, v3_r;
  logic signed [VAL_W-1:0]  dx1_r, dy1_r, dx2_r, dy2_r, dx3_r, dy3_r;
  logic [2*VAL_W-1:0]       sqx_r, sqy_r, d2_r;
  logic signed [VAL_W:0]    dx_w, dy_w;
  logic [VAL_W-1:0]         mx, my;
  logic                     adv;

  assign adv      = !v3_r || !job_full;
  assign in_full  = !adv;
  assign job_push = v3_r && !job_full;

  assign dx_w = $signed({in_first_x[VAL_W-1], in_first_x})
              - $signed({in_second_x[VAL_W-1], in_second_x});
  assign dy_w = $signed({in_first_y[VAL_W-1], in_first_y})
              - $signed({in_second_y[VAL_W-1], in_second_y});

  assign mx = dx1_r[VAL_W-1] ? VAL_W'(-dx1_r) : VAL_W'(dx1_r);
  assign my = dy1_r[VAL_W-1] ? VAL_W'(-dy1_r) : VAL_W'(dy1_r);

  always_comb begin
    job.dx     = dx3_r;
    job.dy     = dy3_r;
    job.d2     = d2_r[D2_W-1:0];
    job.active = d2_r < {{(2*VAL_W-D2_W){1'b0}}, thr_sq, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r <= sat32({{(WIDE_W-VAL_W-1){dx_w[VAL_W]}}, dx_w});
      dy1_r <= sat32({{(WIDE_W-VAL_W-1){dy_w[VAL_W]}}, dy_w});
      sqx_r <= mx * mx;
      sqy_r <= my * my;
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      d2_r  <= sqx_r + sqy_r;
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ppq_mul.sv
`default_nettype none
module ppq_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ppq_pkg::WIDE_W-1:0] a,
  input  logic signed [ppq_pkg::WIDE_W-1:0] b,
  output logic                              done,
  output logic signed [ppq_pkg::WIDE_W-1:0] res
);
  import ppq_pkg::*;

  localparam int ACC_W = 2 * WIDE_W;
  localparam int HW    = WIDE_W / 2;

  logic [WIDE_W-1:0]        am_r, bm_r, prod_r, part;
  logic                     neg_r, busy_r, done_r, pv_r;
  logic [2:0]               cnt_r;
  logic [1:0]               psh_r;
  logic [ACC_W-1:0]         acc_r, addend;
  logic [HW-1:0]            pa, pb;
  logic [ACC_W-FRAC_BITS-1:0] rnd;
  logic [WIDE_W-1:0]        rmag;
  logic signed [WIDE_W-1:0] res_r;

  assign pa   = cnt_r[1] ? am_r[WIDE_W-1:HW] : am_r[HW-1:0];
  assign pb   = cnt_r[0] ? bm_r[WIDE_W-1:HW] : bm_r[HW-1:0];
  assign part = pa * pb;

  always_comb begin
    unique case (psh_r)
      2'd0:    addend = {{WIDE_W{1'b0}}, prod_r};
      2'd1:    addend = {{HW{1'b0}}, prod_r, {HW{1'b0}}};
      2'd2:    addend = {prod_r, {WIDE_W{1'b0}}};
      default: addend = '0;
    endcase
  end

  // the rounding half was preloaded into the accumulator
  assign rnd  = acc_r[ACC_W-1:FRAC_BITS];
  assign rmag = (rnd > (ACC_W-FRAC_BITS)'(WIDE_MAX)) ? WIDE_MAX : rnd[WIDE_W-1:0];

  assign done = done_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        pv_r  <= (cnt_r < 3'd4);
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= a[WIDE_W-1] ? WIDE_W'(-a) : WIDE_W'(a);
      bm_r  <= b[WIDE_W-1] ? WIDE_W'(-b) : WIDE_W'(b);
      neg_r <= a[WIDE_W-1] ^ b[WIDE_W-1];
      acc_r <= ACC_W'(1) << (FRAC_BITS - 1);
    end else if (busy_r) begin
      prod_r <= part;
      psh_r  <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      if (pv_r) acc_r <= acc_r + addend;
      if (cnt_r == 3'd5) res_r <= neg_r ? -$signed(rmag) : $signed(rmag);
    end
  end

endmodule
`default_nettype wire

>>> rtl/ppq_div.sv
`default_nettype none
module ppq_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ppq_pkg::VAL_W:0]    num,
  input  logic [ppq_pkg::ROOT_W-1:0]        den,
  output logic                              done,
  output logic signed [ppq_pkg::WIDE_W-1:0] res
);
  import ppq_pkg::*;

  logic [DIV_W-1:0]  n_r, q_r;
  logic [ROOT_W-1:0] rem_r, den_r;
  logic [ROOT_W:0]   trial;
  logic              ge;
  logic              neg_r, busy_r, done_r;
  logic [5:0]        cnt_r;
  logic [VAL_W:0]    nmag;

  assign nmag  = num[VAL_W] ? (VAL_W+1)'(-num) : (VAL_W+1)'(num);
  assign trial = {rem_r, n_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign res   = neg_r ? -$signed({{(WIDE_W-DIV_W){1'b0}}, q_r})
                       :  $signed({{(WIDE_W-DIV_W){1'b0}}, q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division of (|num| << FRAC_BITS) + den/2, one quotient bit a beat
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= DIV_W'({nmag[VAL_W-1:0], {FRAC_BITS{1'b0}}}) + DIV_W'(den >> 1);
      den_r <= den;
      neg_r <= num[VAL_W];
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_W-2:0], 1'b0};
      rem_r <= ge ? ROOT_W'(trial - {1'b0, den_r}) : trial[ROOT_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> rtl/ppq_back.sv
`default_nettype none
module ppq_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ppq_pkg::cfg_t                    cfg,
  input  logic                             job_valid,
  input  ppq_pkg::job_t                    job,
  output logic                             job_pop,
  input  logic                             out_pop,
  output logic                             out_empty,
  output logic [1:0]                       out_kind,
  output logic [ppq_pkg::IDX_W-1:0]        out_row,
  output logic [ppq_pkg::IDX_W-1:0]        out_column,
  output logic signed [ppq_pkg::VAL_W-1:0] out_value,
  output logic                             out_last
);
  import ppq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQRT = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    MS_GG, MS_PEN, MS_WG, MS_GX, MS_GY, MS_XA, MS_XB, MS_HXX,
    MS_YA, MS_YB, MS_HYY, MS_XY, MS_HXY
  } mstep_t;

  typedef enum logic [1:0] {
    DS_WD, DS_UX, DS_UY
  } dstep_t;

  typedef logic signed [WIDE_W-1:0] wide_t;

  state_t            st_r;
  mstep_t            step_r;
  dstep_t            dstep_r;
  logic              wait_r, active_r;
  logic [4:0]        eidx_r;
  logic [D2_W-1:0]   sv_r, sr_r, sbit_r, s_sum, r_next;
  logic              s_ge;
  logic [4:0]        scnt_r;
  logic [ROOT_W-1:0] d_r;
  wide_t dx_r, dy_r, wd_r, ux_r, uy_r, wg_r, t0_r, t1_r, pen_r;
  wide_t gx_r, gy_r, hxx_r, hyy_r, hxy_r;
  wide_t gap, wval, ma, mb, madd, mres, msat, src, val64;
  logic signed [WIDE_W:0] msum;
  logic signed [VAL_W:0]  dnum;
  wide_t             dres;
  logic              mstart, mdone, dstart, ddone;
  logic              ovalid_r, slot_free, elast;
  logic [1:0]        okind_r;
  logic [IDX_W-1:0]  orow_r, ocol_r;
  logic signed [VAL_W-1:0] oval_r;
  logic              olast_r;
  emit_t             e;

  assign gap  = $signed({{(WIDE_W-REG_W){1'b0}}, cfg.thr})
              - $signed({{(WIDE_W-ROOT_W){1'b0}}, d_r});
  assign wval = $signed({{(WIDE_W-REG_W){1'b0}}, cfg.weight});

  // shift-and-subtract square root, one result bit a beat
  assign s_sum  = sr_r + sbit_r;
  assign s_ge   = sv_r >= s_sum;
  assign r_next = s_ge ? (sr_r >> 1) + sbit_r : sr_r >> 1;

  always_comb begin
    unique case (step_r)
      MS_GG:   begin ma = gap;  mb = gap;  madd = '0;   end
      MS_PEN:  begin ma = wval; mb = t0_r; madd = '0;   end
      MS_WG:   begin ma = wd_r; mb = gap;  madd = '0;   end
      MS_GX:   begin ma = wg_r; mb = dx_r; madd = '0;   end
      MS_GY:   begin ma = wg_r; mb = dy_r; madd = '0;   end
      MS_XA:   begin ma = gap;  mb = ux_r; madd = dx_r; end
      MS_XB:   begin ma = ux_r; mb = t0_r; madd = -gap; end
      MS_HXX:  begin ma = wd_r; mb = t0_r; madd = '0;   end
      MS_YA:   begin ma = gap;  mb = uy_r; madd = dy_r; end
      MS_YB:   begin ma = uy_r; mb = t1_r; madd = -gap; end
      MS_HYY:  begin ma = wd_r; mb = t0_r; madd = '0;   end
      MS_XY:   begin ma = ux_r; mb = t1_r; madd = '0;   end
      MS_HXY:  begin ma = wd_r; mb = t0_r; madd = '0;   end
      default: begin ma = '0;   mb = '0;   madd = '0;   end
    endcase
  end

  assign msum = $signed({mres[WIDE_W-1], mres}) + $signed({madd[WIDE_W-1], madd});
  always_comb begin
    if (msum > $signed({1'b0, WIDE_MAX})) msat = WIDE_MAX;
    else if (msum < -$signed({1'b0, WIDE_MAX})) msat = -WIDE_MAX;
    else msat = msum[WIDE_W-1:0];
  end

  always_comb begin
    unique case (dstep_r)
      DS_WD:   dnum = wval[VAL_W:0];
      DS_UX:   dnum = dx_r[VAL_W:0];
      DS_UY:   dnum = dy_r[VAL_W:0];
      default: dnum = '0;
    endcase
  end

  assign mstart = (st_r == ST_MUL) && !wait_r;
  assign dstart = (st_r == ST_DIV) && !wait_r;

  ppq_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .res   (mres)
  );

  ppq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart),
    .num   (dnum),
    .den   (d_r),
    .done  (ddone),
    .res   (dres)
  );

  function automatic logic [IDX_W-1:0] sel_idx(input sel_t s, input cfg_t c);
    logic [IDX_W-1:0] r;
    unique case (s)
      SEL_X1:  r = c.x1;
      SEL_Y1:  r = c.y1;
      SEL_X2:  r = c.x2;
      SEL_Y2:  r = c.y2;
      default: r = c.x1;
    endcase
    return clamp_idx(r);
  endfunction

  assign e = emit_entry(eidx_r);
  always_comb begin
    unique case (e.src)
      SRC_PEN: src = (pen_r + 64'sd1) >>> 1;
      SRC_GX:  src = gx_r;
      SRC_GY:  src = gy_r;
      SRC_HXX: src = hxx_r;
      SRC_HYY: src = hyy_r;
      SRC_HXY: src = hxy_r;
      default: src = '0;
    endcase
  end
  assign val64     = !active_r ? '0 : (e.neg ? -src : src);
  assign slot_free = !ovalid_r || out_pop;
  assign elast     = !active_r || (eidx_r == 5'(NRES - 1));
  assign job_pop   = (st_r == ST_IDLE) && job_valid;

  assign out_empty  = !ovalid_r;
  assign out_kind   = okind_r;
  assign out_row    = orow_r;
  assign out_column = ocol_r;
  assign out_value  = oval_r;
  assign out_last   = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      wait_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (st_r == ST_EMIT && slot_free) ovalid_r <= 1'b1;
      else if (out_pop) ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (job_valid) st_r <= job.active ? ST_SQRT : ST_EMIT;
        ST_SQRT: if (scnt_r == 5'd0) begin
          st_r   <= ST_MUL;
          wait_r <= 1'b0;
        end
        ST_MUL: begin
          if (!wait_r) wait_r <= 1'b1;
          else if (mdone) begin
            wait_r <= 1'b0;
            if (step_r == MS_PEN) st_r <= (d_r == '0) ? ST_EMIT : ST_DIV;
            else if (step_r == MS_HXY) st_r <= ST_EMIT;
          end
        end
        ST_DIV: begin
          if (!wait_r) wait_r <= 1'b1;
          else if (ddone) begin
            wait_r <= 1'b0;
            if (dstep_r == DS_UY) st_r <= ST_MUL;
          end
        end
        ST_EMIT: if (slot_free && elast) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        dx_r     <= WIDE_W'(job.dx);
        dy_r     <= WIDE_W'(job.dy);
        active_r <= job.active;
        sv_r     <= job.d2;
        sr_r     <= '0;
        sbit_r   <= D2_W'(1) << (2 * (ROOT_W - 1));
        scnt_r   <= 5'(ROOT_W - 1);
        step_r   <= MS_GG;
        dstep_r  <= DS_WD;
        eidx_r   <= '0;
        gx_r     <= '0;
        gy_r     <= '0;
        hxx_r    <= '0;
        hyy_r    <= '0;
        hxy_r    <= '0;
      end
      ST_SQRT: begin
        if (s_ge) sv_r <= sv_r - s_sum;
        sr_r   <= r_next;
        sbit_r <= sbit_r >> 2;
        scnt_r <= scnt_r - 5'd1;
        if (scnt_r == 5'd0) d_r <= r_next[ROOT_W-1:0];
      end
      ST_MUL: if (wait_r && mdone) begin
        unique case (step_r)
          MS_GG:   t0_r  <= msat;
          MS_PEN:  pen_r <= msat;
          MS_WG:   wg_r  <= msat;
          MS_GX:   gx_r  <= -msat;
          MS_GY:   gy_r  <= -msat;
          MS_XA:   t0_r  <= msat;
          MS_XB:   t0_r  <= msat;
          MS_HXX:  hxx_r <= msat;
          MS_YA:   t1_r  <= msat;
          MS_YB:   t0_r  <= msat;
          MS_HYY:  hyy_r <= msat;
          MS_XY:   t0_r  <= msat;
          MS_HXY:  hxy_r <= msat;
          default: t0_r  <= msat;
        endcase
        if (step_r != MS_HXY) step_r <= mstep_t'(step_r + 4'd1);
      end
      ST_DIV: if (wait_r && ddone) begin
        unique case (dstep_r)
          DS_WD:   wd_r <= dres;
          DS_UX:   ux_r <= dres;
          DS_UY:   uy_r <= dres;
          default: wd_r <= dres;
        endcase
        dstep_r <= dstep_t'(dstep_r + 2'd1);
      end
      ST_EMIT: if (slot_free) begin
        okind_r <= e.kind;
        orow_r  <= (e.kind == KIND_PEN) ? '0 : sel_idx(e.row, cfg);
        ocol_r  <= (e.kind == KIND_HESS) ? sel_idx(e.col, cfg) : '0;
        oval_r  <= sat32(val64);
        olast_r <= elast;
        eidx_r  <= eidx_r + 5'd1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mdone |-> (st_r == ST_MUL) && wait_r)
    else $error("multiplier finished outside a multiply step");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> (st_r == ST_DIV) && wait_r)
    else $error("divider finished outside a divide step");

  a_run_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) && slot_free && elast |=> (st_r == ST_IDLE) && ovalid_r && olast_r)
    else $error("run did not close with a last beat");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (st_r == ST_SQRT) || (st_r == ST_EMIT))
    else $error("job taken but no work started");
`endif

endmodule
`default_nettype wire

>>> rtl/proximity_penalty_quadraticizer_unit.sv
`default_nettype none
// Proximity penalty with gradient and Hessian terms for two planar agents, all
// values signed Q16.16 with saturation. Each input beat yields one penalty beat
// when the pair is far apart, or a run of 21 beats (penalty, four gradient terms,
// sixteen Hessian terms, each tagged with state indices) while the penalty is
// active; out_last marks the final beat of a run. A three-stage front computes
// the squared distance and the activity test and queues up to two items, so new
// items are taken while the back end is busy. An active item goes through a 24-step
// square root, three divisions on the shared divider and thirteen products on the
// shared 32x32 multiplier (just two products and no division at zero distance),
// then 21 result beats. Configuration is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce it.
module proximity_penalty_quadraticizer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [ppq_pkg::REG_W-1:0]        cfg_wdata,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_first_x,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_first_y,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_second_x,
  input  logic signed [ppq_pkg::VAL_W-1:0] in_second_y,
  input  logic                             out_pop,
  output logic                             out_empty,
  output logic [1:0]                       out_kind,
  output logic [ppq_pkg::IDX_W-1:0]        out_row,
  output logic [ppq_pkg::IDX_W-1:0]        out_column,
  output logic signed [ppq_pkg::VAL_W-1:0] out_value,
  output logic                             out_last
);
  import ppq_pkg::*;

  cfg_t cfg_r;
  job_t fjob, bjob;
  logic fpush, ffull, fpop, fempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x1     <= IDX_W'(0);
      cfg_r.y1     <= IDX_W'(1);
      cfg_r.x2     <= IDX_W'(2);
      cfg_r.y2     <= IDX_W'(3);
      cfg_r.thr    <= REG_W'(1) << FRAC_BITS;
      cfg_r.thr_sq <= REG_W'(1) << FRAC_BITS;
      cfg_r.weight <= REG_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X1:     cfg_r.x1     <= cfg_wdata[IDX_W-1:0];
        CFG_Y1:     cfg_r.y1     <= cfg_wdata[IDX_W-1:0];
        CFG_X2:     cfg_r.x2     <= cfg_wdata[IDX_W-1:0];
        CFG_Y2:     cfg_r.y2     <= cfg_wdata[IDX_W-1:0];
        CFG_THR:    cfg_r.thr    <= cfg_wdata;
        CFG_THR_SQ: cfg_r.thr_sq <= cfg_wdata;
        CFG_WEIGHT: cfg_r.weight <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ppq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_first_x  (in_first_x),
    .in_first_y  (in_first_y),
    .in_second_x (in_second_x),
    .in_second_y (in_second_y),
    .thr_sq      (cfg_r.thr_sq),
    .job_push    (fpush),
    .job_full    (ffull),
    .job         (fjob)
  );

  ppq_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fpush),
    .wdata (fjob),
    .full  (ffull),
    .pop   (fpop),
    .rdata (bjob),
    .empty (fempty)
  );

  ppq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_valid  (!fempty),
    .job        (bjob),
    .job_pop    (fpop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_kind   (out_kind),
    .out_row    (out_row),
    .out_column (out_column),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

>>> tb/ppq_checker.sv
module ppq_checker
  import ppq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [REG_W-1:0]        cfg_wdata,
  input  logic                    in_push,
  input  logic                    in_full,
  input  logic signed [VAL_W-1:0] in_first_x,
  input  logic signed [VAL_W-1:0] in_first_y,
  input  logic signed [VAL_W-1:0] in_second_x,
  input  logic signed [VAL_W-1:0] in_second_y,
  input  logic                    out_pop,
  input  logic                    out_empty,
  input  logic [1:0]              out_kind,
  input  logic [IDX_W-1:0]        out_row,
  input  logic [IDX_W-1:0]        out_column,
  input  logic signed [VAL_W-1:0] out_value,
  input  logic                    out_last,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] wide_t;

  typedef struct {
    kind_t                   kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } beat_t;

  beat_t beats_due[$];

  logic [IDX_W-1:0] idx_x1, idx_y1, idx_x2, idx_y2;
  logic [REG_W-1:0] thr, thr_sq, wgt;

  assign pending = beats_due.size();

  function automatic logic [63:0] magn(input wide_t a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic wide_t clip_wide(input logic [63:0] r, input logic neg);
    logic [63:0] m;
    m = (r > 64'(WIDE_MAX)) ? 64'(WIDE_MAX) : r;
    return neg ? -wide_t'(m) : wide_t'(m);
  endfunction

  function automatic wide_t qmul(input wide_t a, input wide_t b);
    logic [127:0] p;
    logic [63:0]  r;
    p = 128'(magn(a)) * 128'(magn(b)) + (128'(1) << (FRAC_BITS - 1));
    if ((p >> (64 + FRAC_BITS)) != 0) r = 64'(WIDE_MAX);
    else r = 64'(p >> FRAC_BITS);
    return clip_wide(r, (a < 0) != (b < 0));
  endfunction

  function automatic wide_t qdiv(input wide_t a, input logic [63:0] d);
    logic [63:0] q;
    q = ((magn(a) << FRAC_BITS) + d / 2) / d;
    return clip_wide(q, a < 0);
  endfunction

  function automatic wide_t wadd(input wide_t a, input wide_t b);
    wide_t s;
    s = a + b;
    if (s > WIDE_MAX) s = WIDE_MAX;
    if (s < -WIDE_MAX) s = -WIDE_MAX;
    return s;
  endfunction

  function automatic logic signed [VAL_W-1:0] to_val(input wide_t v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[VAL_W-1:0];
  endfunction

  function automatic wide_t diff32(input logic signed [VAL_W-1:0] a,
                                   input logic signed [VAL_W-1:0] b);
    return wide_t'(to_val(wide_t'(a) - wide_t'(b)));
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] lim_idx(input logic [IDX_W-1:0] i);
    return (32'(i) >= STATE_DIM) ? IDX_W'(STATE_DIM - 1) : i;
  endfunction

  task automatic add_beat(input kind_t k, input logic [IDX_W-1:0] r,
                          input logic [IDX_W-1:0] c, input wide_t v, input logic l);
    beat_t b;
    b.kind = k;
    b.row = r;
    b.column = c;
    b.value = to_val(v);
    b.last = l;
    beats_due.push_back(b);
  endtask

  task automatic predict_penalty(input logic signed [VAL_W-1:0] fx,
                                 input logic signed [VAL_W-1:0] fy,
                                 input logic signed [VAL_W-1:0] sx,
                                 input logic signed [VAL_W-1:0] sy);
    wide_t dx, dy, gap, pen, wd, ux, uy, wg;
    wide_t gx, gy, hxx, hyy, hxy;
    logic [63:0] mx, my, d2, d;
    logic [IDX_W-1:0] x1, y1, x2, y2;
    dx = diff32(fx, sx);
    dy = diff32(fy, sy);
    mx = magn(dx);
    my = magn(dy);
    d2 = mx * mx + my * my;
    x1 = lim_idx(idx_x1);
    y1 = lim_idx(idx_y1);
    x2 = lim_idx(idx_x2);
    y2 = lim_idx(idx_y2);
    gx = 0; gy = 0; hxx = 0; hyy = 0; hxy = 0;
    if (d2 >= (64'(thr_sq) << FRAC_BITS)) begin
      add_beat(KIND_PEN, 0, 0, 0, 1'b1);
      return;
    end
    d = int_root(d2);
    gap = wide_t'(thr) - wide_t'(d);
    pen = qmul(wide_t'(wgt), qmul(gap, gap));
    pen = (pen + 1) >>> 1;
    add_beat(KIND_PEN, 0, 0, pen, 1'b0);
    // coincident agents give zero derivative terms
    if (d != 0) begin
      wd = qdiv(wide_t'(wgt), d);
      ux = qdiv(dx, d);
      uy = qdiv(dy, d);
      wg = qmul(wd, gap);
      gx = -qmul(wg, dx);
      gy = -qmul(wg, dy);
      hxx = qmul(wd, wadd(qmul(ux, wadd(qmul(gap, ux), dx)), -gap));
      hyy = qmul(wd, wadd(qmul(uy, wadd(qmul(gap, uy), dy)), -gap));
      hxy = qmul(wd, qmul(ux, wadd(qmul(gap, uy), dy)));
    end
    add_beat(KIND_GRAD, x1, 0, gx, 0);
    add_beat(KIND_GRAD, x2, 0, -gx, 0);
    add_beat(KIND_GRAD, y1, 0, gy, 0);
    add_beat(KIND_GRAD, y2, 0, -gy, 0);
    add_beat(KIND_HESS, x1, x1, hxx, 0);
    add_beat(KIND_HESS, x1, x2, -hxx, 0);
    add_beat(KIND_HESS, x2, x1, -hxx, 0);
    add_beat(KIND_HESS, x2, x2, hxx, 0);
    add_beat(KIND_HESS, y1, y1, hyy, 0);
    add_beat(KIND_HESS, y1, y2, -hyy, 0);
    add_beat(KIND_HESS, y2, y1, -hyy, 0);
    add_beat(KIND_HESS, y2, y2, hyy, 0);
    add_beat(KIND_HESS, x1, y1, hxy, 0);
    add_beat(KIND_HESS, y1, x1, hxy, 0);
    add_beat(KIND_HESS, x1, y2, -hxy, 0);
    add_beat(KIND_HESS, y2, x1, -hxy, 0);
    add_beat(KIND_HESS, x2, y1, -hxy, 0);
    add_beat(KIND_HESS, y1, x2, -hxy, 0);
    add_beat(KIND_HESS, x2, y2, hxy, 0);
    add_beat(KIND_HESS, y2, x2, hxy, 1);
  endtask

  task automatic report(input string what);
    $display("ppq_checker: %0t: %s", $realtime, what);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    beat_t b;
    if (!rst_n) begin
      idx_x1 <= 0; idx_y1 <= 1; idx_x2 <= 2; idx_y2 <= 3;
      thr <= 65536; thr_sq <= 65536; wgt <= 65536;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_X1:     idx_x1 <= cfg_wdata[IDX_W-1:0];
          CFG_Y1:     idx_y1 <= cfg_wdata[IDX_W-1:0];
          CFG_X2:     idx_x2 <= cfg_wdata[IDX_W-1:0];
          CFG_Y2:     idx_y2 <= cfg_wdata[IDX_W-1:0];
          CFG_THR:    thr <= cfg_wdata;
          CFG_THR_SQ: thr_sq <= cfg_wdata;
          CFG_WEIGHT: wgt <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        predict_penalty(in_first_x, in_first_y, in_second_x, in_second_y);
      if (out_pop && !out_empty) begin
        if (beats_due.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          b = beats_due.pop_front();
          if (out_kind != b.kind || out_row != b.row || out_column != b.column ||
              out_value != b.value || out_last != b.last)
            report($sformatf("got k%0d r%0d c%0d v%0h l%0d, want k%0d r%0d c%0d v%0h l%0d",
                             out_kind, out_row, out_column, out_value, out_last,
                             b.kind, b.row, b.column, b.value, b.last));
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  import ppq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int LIMIT = 2_000_000;
  localparam int DRAIN = 400;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [REG_W-1:0] cfg_wdata;
  logic in_push, in_full;
  logic signed [VAL_W-1:0] in_first_x, in_first_y, in_second_x, in_second_y;
  logic out_pop, out_empty;
  logic [1:0] out_kind;
  logic [IDX_W-1:0] out_row, out_column;
  logic signed [VAL_W-1:0] out_value;
  logic out_last;
  int errors, pending;
  int cycles;
  bit quiet, hold_req;
  logic [REG_W-1:0] cur_thr_sq;

  proximity_penalty_quadraticizer_unit DUT (.*);

  ppq_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_pop = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_pop <= 0;
        repeat (3000) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_pop <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_pop <= 1;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [REG_W-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_THR_SQ) cur_thr_sq = data;
  endtask

  task automatic settle();
    in_push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_pair(input logic signed [VAL_W-1:0] fx, input logic signed [VAL_W-1:0] fy,
                           input logic signed [VAL_W-1:0] sx, input logic signed [VAL_W-1:0] sy);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_push <= 1;
    in_first_x <= fx;
    in_first_y <= fy;
    in_second_x <= sx;
    in_second_y <= sy;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_random();
    int reach, dx, dy;
    logic signed [VAL_W-1:0] sx, sy;
    sx = $urandom;
    sy = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      send_pair($urandom, $urandom, sx, sy);
    end else begin
      // keep the pair inside the threshold so the full run comes out
      reach = int'($sqrt(real'(cur_thr_sq) * 65536.0) * 0.7);
      dx = int'($urandom_range(0, 2 * reach)) - reach;
      dy = int'($urandom_range(0, 2 * reach)) - reach;
      send_pair(sx + dx, sy + dy, sx, sy);
    end
  endtask

  initial begin
    logic [63:0] t;
    logic [REG_W-1:0] thr;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_X1;
    cfg_wdata = 0;
    in_push = 0;
    in_first_x = 0; in_first_y = 0; in_second_x = 0; in_second_y = 0;
    quiet = 0;
    hold_req = 0;
    cur_thr_sq = 65536;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: unit threshold and weight
    send_pair(0, 0, 0, 0);
    send_pair(32'sh0000_8000, 0, 0, 0);
    send_pair(0, -32'sh0000_4000, 0, 32'sh0000_2000);
    send_pair(32'sh0000_3000, 32'sh0000_4000, 0, 0);
    send_pair(-32'sh0000_3000, 32'sh0000_4000, 0, 0);
    send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_pair(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 1);
    send_pair(32'sh0001_0000, 0, 0, 0);
    send_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_pair(32'sh0000_B504, 32'sh0000_B504, 0, 0);

    settle();
    cfg_write(CFG_X1, 0);
    cfg_write(CFG_Y1, 0);
    cfg_write(CFG_X2, 0);
    cfg_write(CFG_Y2, 0);
    cfg_write(CFG_THR, 0);
    cfg_write(CFG_THR_SQ, 0);
    cfg_write(CFG_WEIGHT, 0);
    cfg_write(CFG_UNUSED, '1);
    send_pair(0, 0, 0, 0);
    send_pair(32'sh0000_0001, 0, 0, 0);

    settle();
    cfg_write(CFG_THR_SQ, 1);
    cfg_write(CFG_THR, 31'h7FFF_FFFF);
    cfg_write(CFG_WEIGHT, 31'h7FFF_FFFF);
    send_pair(0, 0, 0, 0);
    send_pair(0, 0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      if (ph == 0) begin
        cfg_write(CFG_X1, 63);
        cfg_write(CFG_Y1, 62);
        cfg_write(CFG_X2, 0);
        cfg_write(CFG_Y2, 31);
        cfg_write(CFG_THR, '1);
        cfg_write(CFG_THR_SQ, '1);
        cfg_write(CFG_WEIGHT, '1);
      end else begin
        cfg_write(CFG_X1, REG_W'($urandom_range(0, 63)));
        cfg_write(CFG_Y1, REG_W'($urandom_range(0, 63)));
        cfg_write(CFG_X2, REG_W'($urandom_range(0, 63)));
        cfg_write(CFG_Y2, REG_W'($urandom_range(0, 63)));
        thr = REG_W'($urandom_range(1, 1 << 24));
        t = (64'(thr) * 64'(thr)) >> FRAC_BITS;
        if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
        if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 32'h7FFF_FFFF);
        cfg_write(CFG_THR, thr);
        cfg_write(CFG_THR_SQ, t[REG_W-1:0]);
        cfg_write(CFG_WEIGHT, REG_W'($urandom_range(0, 32'h7FFF_FFFF)));
      end
      if (ph == 1) hold_req = 1;
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 30; i++) send_random();
    end

    in_push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
